// ===== hdl/imtc_pkg.sv =====
// imtc_pkg: shared types and constants for the ipv4 mask text checker
// no dependencies; imported by imtc_core, ipv4_mask_text_checker_unit and tb_top
package imtc_pkg;

  localparam logic [7:0] CHAR_TERM  = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned PART_W = 9;
  localparam int unsigned WIDE_W = 12;  // holds 255*10+9

  localparam logic [WIDE_W-1:0] OCTET_MAX  = 12'd255;
  localparam logic [WIDE_W-1:0] PREFIX_MAX = 12'd32;
  localparam logic [WIDE_W-1:0] RADIX      = 12'd10;
  localparam logic [1:0]        DOTS_NEEDED = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
  } step_req_t;

  typedef struct packed {
    logic valid;
    logic address_ok;
  } step_rsp_t;

endpackage

// ===== hdl/imtc_core.sv =====
// imtc_core: parser state registers and the per-character update logic
// depends on imtc_pkg
module imtc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  imtc_pkg::step_req_t req,
  output imtc_pkg::step_rsp_t rsp
);
  import imtc_pkg::*;

  logic [PART_W-1:0] part_value_r, part_value_nxt;
  logic              has_digits_r, has_digits_nxt;
  logic [1:0]        dot_count_r, dot_count_nxt;
  logic              in_mask_r, in_mask_nxt;
  logic              failed_r, failed_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [WIDE_W-1:0] wide_value;
  logic [WIDE_W-1:0] limit;

  assign is_digit   = (req.char_code >= CHAR_ZERO) && (req.char_code <= CHAR_NINE);
  assign digit      = req.char_code[3:0];
  assign wide_value = {{(WIDE_W-PART_W){1'b0}}, part_value_r} * RADIX
                      + {{(WIDE_W-4){1'b0}}, digit};
  assign limit      = in_mask_r ? PREFIX_MAX : OCTET_MAX;

  always_comb begin
    part_value_nxt = part_value_r;
    has_digits_nxt = has_digits_r;
    dot_count_nxt  = dot_count_r;
    in_mask_nxt    = in_mask_r;
    failed_nxt     = failed_r;
    rsp.valid      = 1'b0;
    rsp.address_ok = 1'b0;
    if (req.valid) begin
      if (req.char_code == CHAR_TERM) begin
        rsp.valid      = 1'b1;
        rsp.address_ok = !failed_r && (dot_count_r == DOTS_NEEDED) && has_digits_r;
        part_value_nxt = '0;
        has_digits_nxt = 1'b0;
        dot_count_nxt  = '0;
        in_mask_nxt    = 1'b0;
        failed_nxt     = 1'b0;
      end else if (!failed_r) begin
        if (is_digit) begin
          if (!has_digits_r) begin
            part_value_nxt = {{(PART_W-4){1'b0}}, digit};
            has_digits_nxt = 1'b1;
          end else if (part_value_r == '0) begin
            failed_nxt = 1'b1;  // leading zero
          end else if (wide_value > limit) begin
            failed_nxt = 1'b1;
          end else begin
            part_value_nxt = wide_value[PART_W-1:0];
          end
        end else if (req.char_code == CHAR_DOT) begin
          if (dot_count_r == DOTS_NEEDED || !has_digits_r) begin
            failed_nxt = 1'b1;
          end else begin
            dot_count_nxt  = dot_count_r + 2'd1;
            has_digits_nxt = 1'b0;
          end
        end else if (req.char_code == CHAR_SLASH) begin
          if (in_mask_r || !has_digits_r) begin
            failed_nxt = 1'b1;
          end else begin
            in_mask_nxt    = 1'b1;
            has_digits_nxt = 1'b0;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_value_r <= '0;
      has_digits_r <= 1'b0;
      dot_count_r  <= '0;
      in_mask_r    <= 1'b0;
      failed_r     <= 1'b0;
    end else begin
      part_value_r <= part_value_nxt;
      has_digits_r <= has_digits_nxt;
      dot_count_r  <= dot_count_nxt;
      in_mask_r    <= in_mask_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // a terminator leaves the parser in its start state
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && req.char_code == CHAR_TERM |=>
      part_value_r == '0 && !has_digits_r && dot_count_r == '0 && !in_mask_r && !failed_r)
    else $error("parser state not cleared after terminator");

  // rejection holds until the string ends
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !(req.valid && req.char_code == CHAR_TERM) |=> failed_r && $stable(part_value_r))
    else $error("rejection flag dropped mid-string");

  a_octet_range: assert property (@(posedge clk) disable iff (!rst_n)
    part_value_r <= OCTET_MAX[PART_W-1:0])
    else $error("part value above octet range");

  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_mask_r && has_digits_r |-> part_value_r <= PREFIX_MAX[PART_W-1:0])
    else $error("prefix length above limit");

endmodule

// ===== hdl/ipv4_mask_text_checker_unit.sv =====
// ipv4_mask_text_checker_unit: checks dotted-quad ipv4 text with optional /prefix
// path: a terminator item passes the input register, then the parser; its result is registered in the output register
// throughput: one character item per cycle; only a terminator item is held in the input register,
// and only while a finished result waits in the output register and out_stall is high
// reset: synchronous active-low rst_n clears the parser and both valid flags
// depends on imtc_pkg and imtc_core
module ipv4_mask_text_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_address_ok
);
  import imtc_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r, in_char_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r, out_ok_nxt;
  logic       advance;
  step_req_t  req;
  step_rsp_t  rsp;

  // non-terminators never produce an item, so only terminators wait on the output
  assign advance  = in_valid_r && ((in_char_r != CHAR_TERM) || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  assign req.valid     = advance;
  assign req.char_code = in_char_r;

  imtc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_char_nxt  = in_char_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
      in_char_nxt  = in_char_code;
    end
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    if (rsp.valid) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = rsp.address_ok;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_char_r <= in_char_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_address_ok = out_ok_r;

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid |-> !out_valid_r || !out_stall)
    else $error("result dropped in output register");

  // only a terminator is ever held back
  a_stall_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && in_char_r == CHAR_TERM && out_valid_r)
    else $error("input stalled without a pending terminator");

  a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance) && $past(in_char_r) == CHAR_TERM)
    else $error("result without terminator");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for ipv4_mask_text_checker_unit, strings fed one char per item
// depends on imtc_pkg and the DUT; verdicts are pinned or predicted from its own parser copy
module tb_top;
  import imtc_pkg::*;

  localparam int DIR_ROWS        = 23;
  localparam int VERDICT_PREDICT = -1;
  localparam int RANDOM_CHARS    = 1000;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_address_ok;

  // typed verdict that travels with a terminator item of the directed table
  logic pin_on = 1'b0;
  logic pin_ok = 1'b0;

  // shadow parser state
  logic [8:0] part_val   = '0;
  logic       part_open  = 1'b0;
  logic [1:0] dots_seen  = '0;
  logic       mask_seen  = 1'b0;
  logic       rejected   = 1'b0;

  bit         verdict_q[$];
  logic [7:0] text_buf[$];
  int         err_cnt = 0;
  bit         calm_phase = 1'b0;
  bit         hold_go = 1'b0;

  string dir_text [DIR_ROWS] = '{
    "", "0.0.0.0", "255.255.255.255", "256.0.0.1", "01.2.3.4", "1.2.3.4/0",
    "1.2.3.4/32", "1.2.3.4/33", "1..3.4", "1.2.3.4.5", "1.2.3.4/8/9", "/1.2.3.4",
    "1.2.3", "1.2.3.4/", "1.2.3.x", "1\200.2.3.4", "\377", "10.0/24.1.2",
    "99.100.200.250", "a1.2.3.4", "00.0.0.0", "192.168.1.1/24", "1.2.3.2550"
  };
  int dir_verdict [DIR_ROWS] = '{
    0, 1, 1, 0, 0, 1,
    1, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, VERDICT_PREDICT,
    VERDICT_PREDICT, 0, 0, VERDICT_PREDICT, 0
  };

  ipv4_mask_text_checker_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_address_ok(out_address_ok)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // advances the shadow parser by one char; returns 1 when a verdict is due
  function automatic bit parse_char(input logic [7:0] ch, output bit ok);
    logic [7:0]  dig;
    logic [11:0] wide;
    ok = 1'b0;
    if (ch == CHAR_TERM) begin
      ok = !rejected && dots_seen == DOTS_NEEDED && part_open;
      part_val  = '0;
      part_open = 1'b0;
      dots_seen = '0;
      mask_seen = 1'b0;
      rejected  = 1'b0;
      return 1'b1;
    end
    if (rejected) return 1'b0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      dig = ch - CHAR_ZERO;
      if (!part_open) begin
        part_val = {1'b0, dig};
      end else if (part_val == '0) begin
        rejected = 1'b1;
      end else begin
        wide = {3'b000, part_val} * RADIX + {4'h0, dig};
        if ((!mask_seen && wide > OCTET_MAX) || (mask_seen && wide > PREFIX_MAX)) begin
          rejected = 1'b1;
        end else begin
          part_val = wide[8:0];
        end
      end
      if (!rejected) part_open = 1'b1;
    end else if (ch == CHAR_DOT) begin
      if (dots_seen == DOTS_NEEDED || !part_open) begin
        rejected = 1'b1;
      end else begin
        dots_seen = dots_seen + 2'd1;
        part_open = 1'b0;
      end
    end else if (ch == CHAR_SLASH) begin
      if (mask_seen || !part_open) begin
        rejected = 1'b1;
      end else begin
        part_open = 1'b0;
        mask_seen = 1'b1;
      end
    end else begin
      rejected = 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    bit ok;
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected verdict, expected none, actual %0b", $time, out_address_ok);
      end else begin
        want = verdict_q.pop_front();
        if (out_address_ok !== want) begin
          err_cnt++;
          $display("%0t: address_ok mismatch, expected %0b, actual %0b",
                   $time, want, out_address_ok);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      if (parse_char(in_char_code, ok)) verdict_q.push_back(pin_on ? pin_ok : ok);
    end
  end

  // receiver: random stalls, one long hold-off on request, none in the calm phase
  always @(negedge clk) begin : receiver
    int hold_left;
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm_phase || !rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 7);
    end
  end

  task automatic put_char(input logic [7:0] c, input logic pon, input logic pok);
    int gap;
    if (!calm_phase && $urandom_range(99) < 3) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_char_code <= c;
    pin_on       <= pon;
    pin_ok       <= pok;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_buf(input bit pinned, input bit verdict);
    foreach (text_buf[i]) put_char(text_buf[i], 1'b0, 1'b0);
    put_char(CHAR_TERM, pinned, verdict);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic push_part(input int v);
    if ($urandom_range(19) == 0) text_buf.push_back(CHAR_ZERO);
    push_text($sformatf("%0d", v));
  endtask

  function automatic int pick_octet();
    case ($urandom_range(29))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(256, 999);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_prefix();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 32;
      2:       return $urandom_range(33, 99);
      default: return $urandom_range(0, 32);
    endcase
  endfunction

  // mostly well-formed addresses, some with one corruption, the rest noise
  task automatic build_random();
    int kind;
    int pos;
    int n;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(12);
      repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      for (int p = 0; p < 4; p++) begin
        push_part(pick_octet());
        if (p < 3) text_buf.push_back(CHAR_DOT);
      end
      if ($urandom_range(1)) begin
        text_buf.push_back(CHAR_SLASH);
        push_part(pick_prefix());
      end
      if (kind < 35) begin
        pos = $urandom_range(text_buf.size() - 1);
        case ($urandom_range(4))
          0: text_buf.delete(pos);
          1: text_buf.insert(pos, 8'($urandom_range(1, 255)));
          2: text_buf.insert(pos, CHAR_DOT);
          3: text_buf.insert(pos, CHAR_SLASH);
          default: begin
            while (text_buf.size() > pos) void'(text_buf.pop_back());
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int sent;
    int strings;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      text_buf.delete();
      push_text(dir_text[r]);
      if (dir_verdict[r] == VERDICT_PREDICT) send_buf(1'b0, 1'b0);
      else send_buf(1'b1, dir_verdict[r][0]);
    end
    wait_drained();

    sent = 0;
    strings = 0;
    while (sent < RANDOM_CHARS) begin
      if (strings == 10) hold_go = 1'b1;
      if (strings == 40) wait_drained();
      calm_phase = (strings >= 50 && strings < 66);
      build_random();
      sent += text_buf.size() + 1;
      send_buf(1'b0, 1'b0);
      strings++;
    end
    calm_phase = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      err_cnt++;
      $display("%0t: verdicts never arrived, expected %0d more, actual 0",
               $time, verdict_q.size());
    end
    if (err_cnt == 0) begin
      $display("[ipv4_mask_text_checker_unit] OK");
    end else begin
      $display("[ipv4_mask_text_checker_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("[ipv4_mask_text_checker_unit] ERROR");
    $finish;
  end

endmodule

// ===== ipv4_mask_text_checker_unit.f =====
hdl/imtc_pkg.sv
hdl/imtc_core.sv
hdl/ipv4_mask_text_checker_unit.sv
test/tb_top.sv
